// ===== rtl/frame_receiver_ack_generator_macros.svh =====
// assertion macros shared by the frame receiver rtl
`ifndef FRAME_RECEIVER_ACK_GENERATOR_MACROS_SVH
`define FRAME_RECEIVER_ACK_GENERATOR_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define FRACK_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver assertion failed");

// next-cycle implication, checked at every rising clock edge outside reset
`define FRACK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver assertion failed");

`endif

// ===== rtl/frack_pkg.sv =====
// shared constants, types and helpers of the frame receiver
package frack_pkg;

   // link framing bytes
   localparam logic [7:0] FLAG_A     = 8'h7E;
   localparam logic [7:0] FLAG_START = 8'hA5;
   localparam logic [7:0] FLAG_END   = 8'hA6;
   localparam logic [7:0] REPLY_ACK  = 8'h01;
   localparam logic [7:0] REPLY_NAK  = 8'h02;

   // reply frame length and beat counting
   localparam int REPLY_LEN = 6;
   localparam int BEAT_W    = 3;
   localparam int TOTAL_W   = 4;

   // default command queue depth
   localparam int QUEUE_DEPTH_DEF = 4;

   // parser phases
   typedef enum logic [3:0] {
      PH_F1,
      PH_F2,
      PH_SEQ,
      PH_FIRST,
      PH_LOW,
      PH_LOW_ESC,
      PH_HIGH,
      PH_HIGH_ESC,
      PH_CK1,
      PH_CK2,
      PH_DONE_ACK,
      PH_DONE_NAK,
      PH_BAD
   } phase_type;

   // one command from the parser: up to two payload beats and an optional reply
   typedef struct packed {
      logic [1:0] pay_count;
      logic [7:0] pay0;
      logic [7:0] pay1;
      logic       reply;
      logic [7:0] seq;
      logic       ack;
   } cmd_type;

   // byte at a given position of the reply frame
   function automatic logic [7:0] reply_byte(input logic [BEAT_W-1:0] pos,
                                             input logic [7:0] seq,
                                             input logic ack);
      logic [7:0] res;
      case (pos)
         3'd0:    res = FLAG_A;
         3'd1:    res = FLAG_START;
         3'd2:    res = seq;
         3'd3:    res = ack ? REPLY_ACK : REPLY_NAK;
         3'd4:    res = FLAG_A;
         3'd5:    res = FLAG_END;
         default: res = FLAG_END;
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/frack_parser.sv =====
// front end: frame parser that turns received bytes into payload and reply commands
module frack_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       rx_byte,
   input  logic             frame_end,
   output logic             push,
   output frack_pkg::cmd_type cmd
);
   import frack_pkg::*;

   phase_type  phase_ff, phase_in, phase_step;
   logic [7:0] next_exp_ff, next_exp_in;
   logic [7:0] seq_ff, seq_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0] high_ff, high_in;
   logic [7:0] ck_hi_ff, ck_hi_in;
   logic       sum_match, seq_equal;

   // checksum and sequence compares
   assign sum_match = ({ck_hi_ff, rx_byte} == sum_ff);
   assign seq_equal = (next_exp_ff == seq_ff);

   // next phase
   always_comb begin
      phase_step = phase_ff;
      case (phase_ff)
         PH_F1:       phase_step = (rx_byte == FLAG_A) ? PH_F2 : PH_BAD;
         PH_F2:       phase_step = (rx_byte == FLAG_START) ? PH_SEQ : PH_BAD;
         PH_SEQ:      phase_step = PH_FIRST;
         PH_FIRST:    phase_step = PH_LOW;
         PH_HIGH:     phase_step = (rx_byte == FLAG_A) ? PH_HIGH_ESC : PH_LOW;
         PH_HIGH_ESC: phase_step = (rx_byte == FLAG_END) ? PH_CK1 : PH_LOW;
         PH_LOW:      phase_step = (rx_byte == FLAG_A) ? PH_LOW_ESC : PH_HIGH;
         PH_LOW_ESC:  phase_step = (rx_byte == FLAG_END) ? PH_CK1 : PH_HIGH;
         PH_CK1:      phase_step = PH_CK2;
         PH_CK2:      phase_step = (sum_match && seq_equal) ? PH_DONE_ACK : PH_DONE_NAK;
         default:     phase_step = phase_ff;
      endcase
      phase_in = frame_end ? PH_F1 : phase_step;
   end

   // datapath updates and command contents
   always_comb begin
      next_exp_in   = next_exp_ff;
      seq_in        = seq_ff;
      sum_in        = sum_ff;
      high_in       = high_ff;
      ck_hi_in      = ck_hi_ff;
      cmd.pay_count = 2'd0;
      cmd.pay0      = rx_byte;
      cmd.pay1      = rx_byte;
      case (phase_ff)
         PH_SEQ: begin
            seq_in = rx_byte;
            sum_in = '0;
         end
         PH_FIRST, PH_HIGH: begin
            if (!(phase_ff == PH_HIGH && rx_byte == FLAG_A)) begin
               cmd.pay_count = 2'd1;
               high_in       = rx_byte;
            end
         end
         PH_HIGH_ESC: begin
            if (rx_byte != FLAG_END) begin
               cmd.pay_count = 2'd2;
               cmd.pay0      = FLAG_A;
               high_in       = rx_byte;
            end
         end
         PH_LOW: begin
            if (rx_byte != FLAG_A) begin
               cmd.pay_count = 2'd1;
               sum_in        = sum_ff ^ {high_ff, rx_byte};
            end
         end
         PH_LOW_ESC: begin
            if (rx_byte != FLAG_END) begin
               cmd.pay_count = 2'd2;
               cmd.pay0      = FLAG_A;
               sum_in        = sum_ff ^ {high_ff, rx_byte};
            end
         end
         PH_CK1: begin
            ck_hi_in = rx_byte;
         end
         PH_CK2: begin
            // a good checksum settles the expected sequence
            if (sum_match) begin
               if (seq_equal) begin
                  next_exp_in = next_exp_ff + 8'd1;
               end else if (next_exp_ff < seq_ff) begin
                  seq_in = next_exp_ff;
               end else begin
                  next_exp_in = seq_ff;
               end
            end
         end
         default: begin
         end
      endcase
      cmd.reply = frame_end;
      cmd.seq   = seq_in;
      cmd.ack   = (phase_step == PH_DONE_ACK);
      push      = accept && (frame_end || cmd.pay_count != 2'd0);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_F1;
         next_exp_ff <= 8'd1;
         seq_ff      <= 8'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         next_exp_ff <= next_exp_in;
         seq_ff      <= seq_in;
      end
   end

   // checksum datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         sum_ff   <= sum_in;
         high_ff  <= high_in;
         ck_hi_ff <= ck_hi_in;
      end
   end

endmodule

// ===== rtl/frack_queue.sv =====
// short command queue between the parser and the beat sender
module frack_queue #(
   parameter int DEPTH = frack_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frack_pkg::cmd_type push_data,
   input  logic             pop,
   output frack_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);
   import frack_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == CNT_W'(0));
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/frack_sender.sv =====
// back end: expands each queued command into result beats
module frack_sender (
   input  logic             clock,
   input  logic             reset,
   input  frack_pkg::cmd_type head,
   input  logic             empty,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tuser,
   output logic             rsp_tlast
);
   import frack_pkg::*;

   logic [BEAT_W-1:0]  idx_ff, idx_in;
   logic [TOTAL_W-1:0] beat_total;
   logic [BEAT_W-1:0]  reply_pos;
   logic               in_payload, last_beat, beat_done;

   // beat count of the head command
   assign beat_total = TOTAL_W'(head.pay_count)
                     + (head.reply ? TOTAL_W'(REPLY_LEN) : TOTAL_W'(0));
   assign last_beat  = ({1'b0, idx_ff} == beat_total - TOTAL_W'(1));
   assign in_payload = ({1'b0, idx_ff} < {1'b0, head.pay_count});
   assign reply_pos  = idx_ff - BEAT_W'(head.pay_count);

   // beat contents
   assign rsp_tvalid = !empty;
   assign rsp_tuser  = !in_payload;
   assign rsp_tdata  = in_payload ? (idx_ff[0] ? head.pay1 : head.pay0)
                                  : reply_byte(reply_pos, head.seq, head.ack);
   assign rsp_tlast  = last_beat;
   assign beat_done  = rsp_tvalid && rsp_tready;
   assign pop        = beat_done && last_beat;

   // position within the command
   always_comb begin
      idx_in = idx_ff;
      if (beat_done) begin
         idx_in = last_beat ? '0 : idx_ff + BEAT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== rtl/frame_receiver_ack_generator.sv =====
// top level of the flag-delimited frame receiver with ack/nak reply
// Use:
//   req channel: one received link byte per beat in req_tdata, req_tlast marks
//   the last byte of a receive buffer.
//   rsp channel: delivered payload bytes (rsp_tuser 0) and the six-byte reply
//   frame (rsp_tuser 1) sent at each buffer end; rsp_tlast flags the last
//   result beat caused by one input beat.
// Output: the first result of an input beat is offered in the cycle after the
//   beat is taken, when the queue ahead of it is empty.
// Throughput: the parser takes one beat per cycle while the command queue has
//   room; the sender drives one result beat per cycle while rsp_tready is high,
//   and each buffer end adds a six-byte reply frame; the queue of QUEUE_DEPTH
//   commands absorbs the backlog before req_tready falls.
// Reset: synchronous, active high; the parser waits for the first start flag,
//   the expected sequence is 1, the last reply sequence is 0, the queue is empty.
// Stall: while rsp_tready is low the current beat holds; the parser keeps
//   taking bytes until the queue fills, then req_tready goes low.
module frame_receiver_ack_generator #(
   parameter int QUEUE_DEPTH = frack_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] kind
   output logic       rsp_tlast
);
   import frack_pkg::*;

   `include "frame_receiver_ack_generator_macros.svh"

   cmd_type push_cmd, head_cmd;
   logic    accept, push, pop, q_empty, q_full;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // front: parse and classify
   frack_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_tdata),
      .frame_end (req_tlast),
      .push      (push),
      .cmd       (push_cmd)
   );

   // command queue
   frack_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .head      (head_cmd),
      .empty     (q_empty),
      .full      (q_full)
   );

   // back: beat sender
   frack_sender u_sender (
      .clock      (clock),
      .reset      (reset),
      .head       (head_cmd),
      .empty      (q_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // checks
   `FRACK_ASSERT_IMP(a_reply_ends_with_flag, clock, reset, rsp_tvalid && rsp_tlast && rsp_tuser, rsp_tdata == FLAG_END)
   `FRACK_ASSERT_NEXT(a_buffer_end_gives_reply, clock, reset, accept && req_tlast, rsp_tvalid)
   `FRACK_ASSERT_NEXT(a_reset_empties_output, clock, 1'b0, reset, !rsp_tvalid)

endmodule
